[src/swm_pkg.sv]
// Shared types, codes and constants for the star wildcard matcher.
package swm_pkg;

    localparam int PAT_MAX_DEF = 16;
    localparam logic [7:0] STAR_BYTE = 8'd42;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_TEXT   = 2'd2,
        FUNC_END    = 2'd3
    } func_t;

    typedef struct packed {
        logic       go;
        func_t      func;
        logic [7:0] symbol;
    } cmd_t;

    typedef struct packed {
        logic matched;
        logic overflow;
    } result_t;

endpackage

[src/swm_closure.sv]
// Star closure of a prefix set, done as one carry chain through the star positions.
module swm_closure #(
    parameter int N = 17
) (
    input  logic [N-1:0] seed,
    input  logic [N-1:0] prop,
    output logic [N-1:0] closed
);
    logic [N:0] a_ext;
    logic [N:0] s_ext;
    logic [N:0] sum;
    logic [N:0] carry;

    // A set bit generates a carry; a star position passes it on to the next bit.
    always_comb
    begin
        a_ext  = {1'b0, seed | prop};
        s_ext  = {1'b0, seed};
        sum    = a_ext + s_ext;
        carry  = sum ^ a_ext ^ s_ext;
        closed = seed | (carry[N-1:0] & prop);
    end

endmodule

[src/swm_engine.sv]
// Pattern store, pattern length, prefix-set automaton and overflow flag.
module swm_engine #(
    parameter int PAT_MAX = swm_pkg::PAT_MAX_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  swm_pkg::cmd_t    cmd,
    output swm_pkg::result_t res
);
    import swm_pkg::*;

    localparam int N     = PAT_MAX + 1;
    localparam int LEN_W = $clog2(PAT_MAX + 1);
    localparam int IDX_W = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;

    logic [7:0]       pat_mem [PAT_MAX];
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [N-1:0]     prefix_reg;
    logic [N-1:0]     prefix_next;
    logic             ovf_reg;
    logic             ovf_next;

    logic [PAT_MAX-1:0] live;
    logic [PAT_MAX-1:0] is_star;
    logic [PAT_MAX-1:0] is_hit;
    logic [N-1:0]       step_raw;
    logic [N-1:0]       prop;
    logic [N-1:0]       step_closed;
    logic [N-1:0]       restart_closed;
    logic               room;
    logic               mem_we;
    logic [LEN_W-1:0]   len_plus;

    always_comb
    begin
        for (int i = 0; i < PAT_MAX; i++)
        begin
            live[i]    = (LEN_W'(i) < len_reg);
            is_star[i] = (pat_mem[i] == STAR_BYTE);
            is_hit[i]  = (pat_mem[i] == cmd.symbol);
        end
    end

    // One text byte moves every live prefix: a star keeps it, a literal hit advances it.
    always_comb
    begin
        step_raw = '0;
        prop     = '0;
        for (int i = 0; i < PAT_MAX; i++)
        begin
            if (prefix_reg[i] && live[i] && is_star[i])
            begin
                step_raw[i] = 1'b1;
            end
            if (prefix_reg[i] && live[i] && !is_star[i] && is_hit[i])
            begin
                step_raw[i + 1] = 1'b1;
            end
            prop[i + 1] = live[i] && is_star[i];
        end
    end

    swm_closure #(
        .N(N)
    ) u_closure (
        .seed  (step_raw),
        .prop  (prop),
        .closed(step_closed)
    );

    // A restarted text holds the empty prefix and every run of leading stars after it.
    swm_closure #(
        .N(N)
    ) u_restart (
        .seed  (N'(1)),
        .prop  (prop),
        .closed(restart_closed)
    );

    assign room     = (len_reg < LEN_W'(PAT_MAX));
    assign len_plus = len_reg + LEN_W'(1);

    // The stored prefix set is kept closed under stars at all times.
    always_comb
    begin
        len_next    = len_reg;
        prefix_next = prefix_reg;
        ovf_next    = ovf_reg;
        mem_we      = 1'b0;
        if (cmd.go)
        begin
            unique case (cmd.func)
                FUNC_CLEAR:
                begin
                    len_next    = '0;
                    ovf_next    = 1'b0;
                    prefix_next = N'(1);
                end
                FUNC_APPEND:
                begin
                    if (room)
                    begin
                        mem_we   = 1'b1;
                        len_next = len_plus;
                        if ((cmd.symbol == STAR_BYTE) && prefix_reg[len_reg])
                        begin
                            prefix_next[len_plus] = 1'b1;
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                FUNC_TEXT:
                begin
                    prefix_next = step_closed;
                end
                FUNC_END:
                begin
                    prefix_next = restart_closed;
                end
                default:
                begin
                    prefix_next = prefix_reg;
                end
            endcase
        end
    end

    assign res.matched  = prefix_reg[len_reg];
    assign res.overflow = ovf_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pat_mem[len_reg[IDX_W-1:0]] <= cmd.symbol;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            prefix_reg <= N'(1);
            ovf_reg    <= 1'b0;
        end
        else
        begin
            len_reg    <= len_next;
            prefix_reg <= prefix_next;
            ovf_reg    <= ovf_next;
        end
    end

endmodule

[src/star_wildcard_matcher.sv]
// Top level of the star wildcard matcher: input register, engine and result register.
//
//   channel  | handshake                | fields
//   ---------+--------------------------+------------------
//   input    | in_valid / in_stall      | func, symbol
//   result   | out_valid / out_stall    | matched, overflow
//
// Each word is executed by the engine while it sits in the input register. One word per
// cycle is sustained while no end-of-text word waits; the result word of an end-of-text
// word is loaded into the result register when the engine executes it, and no other
// word gives a result.
// Reset empties the pattern, clears the overflow flag and the text state, and drops any
// pending word. The pattern store itself is not cleared.
// An end-of-text word waits in the input register while the result register is full and
// stalled, and then in_stall is raised; all other words never wait.
module star_wildcard_matcher #(
    parameter int PAT_MAX = swm_pkg::PAT_MAX_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] func,
    input  logic [7:0] symbol,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       matched,
    output logic       overflow
);
    import swm_pkg::*;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    func_t      func_reg;
    logic [7:0] symbol_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       matched_reg;
    logic       overflow_reg;

    logic       out_free;
    logic       s1_go;
    logic       in_take;
    logic       res_load;
    cmd_t       cmd;
    result_t    res;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_go    = s1_valid_reg && ((func_reg != FUNC_END) || out_free);
    assign in_stall = s1_valid_reg && !s1_go;
    assign in_take  = in_valid && !in_stall;
    assign res_load = s1_go && (func_reg == FUNC_END);

    assign cmd.go     = s1_go;
    assign cmd.func   = func_reg;
    assign cmd.symbol = symbol_reg;

    swm_engine #(
        .PAT_MAX(PAT_MAX)
    ) u_engine (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd),
        .res  (res)
    );

    always_comb
    begin
        s1_valid_next = in_take || (s1_valid_reg && !s1_go);
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg   <= func_t'(func);
            symbol_reg <= symbol;
        end
        if (res_load)
        begin
            matched_reg  <= res.matched;
            overflow_reg <= res.overflow;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;
    assign overflow  = overflow_reg;

endmodule

[src/swm_checker.sv]
// Port-level checks for the star wildcard matcher and the bind that attaches them.
module swm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [1:0] func,
    input logic [7:0] symbol,
    input logic       out_valid,
    input logic       out_stall,
    input logic       matched,
    input logic       overflow
);
    import swm_pkg::*;

    logic end_take;

    assign end_take = in_valid && !in_stall && (func == FUNC_END);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(matched) && $stable(overflow))
        else $error("Stalled result word changed or vanished.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("Input stalled while the result side was free.");

    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        end_take |-> ##2 out_valid)
        else $error("End-of-text word gave no result word.");

    a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(end_take, 2))
        else $error("Result word without an end-of-text word.");

endmodule

bind star_wildcard_matcher swm_checker u_swm_checker (.*);
